// ===== rtl/frt_pkg.sv =====
// Shared types and constants for the fragment reassembly tracker.
// No dependencies; imported by every module under rtl/.
package frt_pkg;

  localparam int ID_W    = 16;
  localparam int TOT_W   = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 7;
  localparam int FREED_W = 4;
  localparam int BMP_W   = 64;

  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd10000;
  localparam logic [FREED_W-1:0] FREED_MAX     = 4'd15;

  // command queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_PRUNE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_PRUNED   = 3'd5,
    ST_CLEARED  = 3'd6,
    ST_RANGE    = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   message_id;
    logic [TOT_W-1:0]  chunk_index;
    logic [TOT_W-1:0]  total_chunks;
    logic [TIME_W-1:0] now_ms;
  } frt_in_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    message_id_out;
    logic [BMP_W-1:0]   received_bitmap;
    logic [CNT_W-1:0]   received_count;
    logic [FREED_W-1:0] freed_count;
  } frt_out_t;

  // classified command as queued for the back end
  typedef struct packed {
    op_t               op;
    logic              range_err;
    logic [ID_W-1:0]   id;
    logic [TOT_W-1:0]  chunk;
    logic [TOT_W-1:0]  total;
    logic [TIME_W-1:0] now;
  } frt_cmd_t;

endpackage

// ===== rtl/frt_front.sv =====
// Front end: takes input transfers, decodes the operation and flags chunk
// indices out of range, then pushes the command into the queue. Uses frt_pkg.
module frt_front #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  frt_pkg::frt_in_t  in_data,
  output logic              push,
  output frt_pkg::frt_cmd_t push_cmd,
  input  logic              q_full
);
  import frt_pkg::*;

  logic     fv;
  frt_cmd_t cmd;
  logic     accept;

  assign in_stall = fv && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fv && !q_full;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op        <= op_t'(in_data.operation);
      cmd.range_err <= (in_data.chunk_index >= TOT_W'(MAX_CHUNKS));
      cmd.id        <= in_data.message_id;
      cmd.chunk     <= in_data.chunk_index;
      cmd.total     <= in_data.total_chunks;
      cmd.now       <= in_data.now_ms;
    end
  end

endmodule

// ===== rtl/frt_queue.sv =====
// Short command FIFO between the front and back ends.
// Uses frt_pkg for the command type and depth.
module frt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  frt_pkg::frt_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output frt_pkg::frt_cmd_t q_cmd
);
  import frt_pkg::*;

  frt_cmd_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/frt_back.sv =====
// Back end: session table, timeout register and result register. Each
// command is executed by parallel compare. Uses frt_pkg.
module frt_back #(
  parameter int SESSIONS   = 8,
  parameter int MAX_CHUNKS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [frt_pkg::TIME_W-1:0] cfg_wdata,
  input  logic                       q_valid,
  input  frt_pkg::frt_cmd_t          q_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output frt_pkg::frt_out_t          out_data
);
  import frt_pkg::*;

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CH_W  = $clog2(MAX_CHUNKS);
  localparam int POP_W = $clog2(SESSIONS + 1);

  logic [TIME_W-1:0]     timeout_ms;
  logic [SESSIONS-1:0]   ent_valid;
  logic [ID_W-1:0]       ent_id    [SESSIONS];
  logic [TOT_W-1:0]      ent_total [SESSIONS];
  logic [CNT_W-1:0]      ent_count [SESSIONS];
  logic [TIME_W-1:0]     ent_start [SESSIONS];
  logic [MAX_CHUNKS-1:0] ent_bmp   [SESSIONS];

  logic [SESSIONS-1:0]   match;
  logic [SESSIONS-1:0]   expire;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      free_idx;
  logic                  hit;
  logic                  any_free;
  logic [IDX_W-1:0]      sel;
  logic [TOT_W-1:0]      total_eff;
  logic [MAX_CHUNKS-1:0] old_bmp;
  logic [CNT_W-1:0]      old_cnt;
  logic [MAX_CHUNKS-1:0] chunk_bit;
  logic [MAX_CHUNKS-1:0] new_bmp;
  logic [CNT_W-1:0]      new_cnt;
  logic [MAX_CHUNKS-1:0] tot_mask;
  logic                  complete;
  logic                  pkt_ok;
  logic                  wr_alloc;
  logic                  wr_upd;
  logic [POP_W-1:0]      n_expired;
  frt_out_t              res;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < SESSIONS; i++) begin
      match[i]  = ent_valid[i] && (ent_id[i] == q_cmd.id);
      // wrapping age
      expire[i] = ent_valid[i] && ((q_cmd.now - ent_start[i]) > timeout_ms);
    end
  end

  // lowest-numbered match and lowest-numbered free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SESSIONS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!ent_valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign any_free  = ~&ent_valid;
  assign sel       = hit ? hit_idx : free_idx;
  assign total_eff = hit ? ent_total[sel] : q_cmd.total;
  assign old_bmp   = hit ? ent_bmp[sel] : '0;
  assign old_cnt   = hit ? ent_count[sel] : '0;
  assign chunk_bit = {{(MAX_CHUNKS - 1){1'b0}}, 1'b1} << q_cmd.chunk[CH_W-1:0];
  assign new_bmp   = old_bmp | chunk_bit;
  assign new_cnt   = old_cnt + CNT_W'(~|(old_bmp & chunk_bit));
  assign complete  = ({1'b0, new_cnt} == total_eff);
  assign n_expired = POP_W'($countones(expire));

  always_comb begin
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      tot_mask[i] = (TOT_W'(i) < total_eff);
    end
  end

  assign pkt_ok   = (q_cmd.op == OP_PACKET) && !q_cmd.range_err && (hit || any_free);
  assign wr_alloc = pop && pkt_ok && !hit;
  assign wr_upd   = pop && pkt_ok;

  always_comb begin
    res                = '0;
    res.status         = ST_STORED;
    res.message_id_out = q_cmd.id;
    unique case (q_cmd.op)
      OP_PACKET: begin
        if (q_cmd.range_err) begin
          res.status = ST_RANGE;
        end else if (!(hit || any_free)) begin
          res.status = ST_FULL;
        end else begin
          res.status          = complete ? ST_COMPLETE : ST_STORED;
          res.received_bitmap = BMP_W'(new_bmp & tot_mask);
          res.received_count  = new_cnt;
        end
      end
      OP_PRUNE: begin
        res.status         = ST_PRUNED;
        res.message_id_out = '0;
        res.freed_count    = (n_expired > POP_W'(FREED_MAX)) ? FREED_MAX
                                                             : FREED_W'(n_expired);
      end
      OP_QUERY: begin
        if (hit) begin
          res.status          = ST_FOUND;
          res.received_bitmap = BMP_W'(ent_bmp[hit_idx] & tot_mask);
          res.received_count  = ent_count[hit_idx];
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      OP_CLEAR: begin
        res.status         = ST_CLEARED;
        res.message_id_out = '0;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (pop) begin
      case (q_cmd.op)
        OP_PACKET: begin
          if (pkt_ok) begin
            ent_valid[sel] <= !complete;
          end
        end
        OP_PRUNE: ent_valid <= ent_valid & ~expire;
        OP_CLEAR: ent_valid <= '0;
        default:  ent_valid <= ent_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_alloc) begin
      ent_id[sel]    <= q_cmd.id;
      ent_total[sel] <= q_cmd.total;
      ent_start[sel] <= q_cmd.now;
    end
    if (wr_upd) begin
      ent_bmp[sel]   <= new_bmp;
      ent_count[sel] <= new_cnt;
    end
  end

  // result register; a new transfer can load while the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && q_cmd.op == OP_CLEAR) |=> (ent_valid == '0))
    else $error("table not empty after clear");

  a_stored_has_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_STORED || out_data.status == ST_COMPLETE))
      |-> (out_data.received_count != '0))
    else $error("stored packet reports zero chunks");

  a_freed_only_prune: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_PRUNED) |-> (out_data.freed_count == '0))
    else $error("freed count outside prune");

  a_complete_frees: assert property (@(posedge clk) disable iff (rst)
    (pop && pkt_ok && complete) |=> !ent_valid[$past(sel)])
    else $error("completed session still valid");

endmodule

// ===== rtl/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker: a table of SESSIONS message sessions keyed by
// message id. A packet, prune, query or clear is one input transfer and
// gives exactly one result transfer. One item is taken every cycle when the
// output is not stalled; each result passes through the front register, the
// command queue and the result register. The rate is set by the back end,
// which looks up, updates and prunes the whole table by parallel compare.
// timeout_ms resets to 10000 and should be written only while the block is
// idle.
module fragment_reassembly_tracker #(
  parameter int SESSIONS   = 8,
  parameter int MAX_CHUNKS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [frt_pkg::TIME_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  frt_pkg::frt_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output frt_pkg::frt_out_t          out_data
);
  import frt_pkg::*;

  logic     push;
  frt_cmd_t push_cmd;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  frt_cmd_t q_cmd;

  frt_front #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  frt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  frt_back #(
    .SESSIONS  (SESSIONS),
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
